// ===== hdl/ppds_pkg.sv =====
// Package for the pairwise point distance scan.
// Holds the queued item type, datapath widths and fixed-point constants.
// No dependencies.
`default_nettype none
package ppds_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int SQ_IN_W  = 56;   // root unit operand width
   localparam int SQ_OUT_W = 28;   // root width
   localparam int SQ_REM_W = 31;   // partial remainder width
   localparam int S_W      = 58;   // u + t before the log
   localparam int MUL_W    = 34;   // shared signed multiplier operand
   localparam int PROD_W   = 68;
   localparam int M_W      = 31;   // log mantissa, Q.30
   localparam int L_W      = 29;   // log2 result, Q.24
   localparam int E_W      = 5;
   localparam int LN_BITS  = 24;

   localparam logic [SQ_IN_W-1:0] ONE_Q32 = 56'h00_0001_0000_0000;
   localparam logic [31:0]        LN2_Q32 = 32'd2977044472;

   localparam logic [1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [1:0] CSR_DIMS        = 2'd1;
   localparam logic [1:0] CSR_HYPERBOLIC  = 2'd2;
   localparam logic [1:0] CSR_SCALE       = 2'd3;

   typedef struct packed {
      logic               is_step;
      logic               load_ok;
      logic [5:0]         point_index;
      logic [2:0]         dim_index;
      logic signed [23:0] coord_value;
   } req_item_type;

   typedef struct packed {
      logic                done;
      logic [SQ_OUT_W-1:0] root;
   } sq_rsp_type;

endpackage
`default_nettype wire

// ===== hdl/ppds_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none
module ppds_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule
`default_nettype wire

// ===== hdl/ppds_isqrt.sv =====
// Iterative integer square root, one root bit per cycle (floor result).
// Depends on ppds_pkg.
`default_nettype none
module ppds_isqrt
   import ppds_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SQ_IN_W-1:0] operand,
   output sq_rsp_type              rsp
);
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [SQ_IN_W-1:0]  val_ff, val_in;
   logic [SQ_REM_W-1:0] rem_ff, rem_in;
   logic [SQ_OUT_W-1:0] root_ff, root_in;
   logic [SQ_REM_W-1:0] rem_shift, trial;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      rem_shift = {rem_ff[SQ_REM_W-3:0], val_ff[SQ_IN_W-1 -: 2]};
      trial     = SQ_REM_W'({root_ff, 2'b01});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(SQ_OUT_W - 1);
         val_in  = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[SQ_IN_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[SQ_OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[SQ_OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("root unit restarted while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("root unit done while still busy");
endmodule
`default_nettype wire

// ===== hdl/ppds_front.sv =====
// Front end: takes request beats, classifies them and queues them for the back end.
// Depends on ppds_pkg.
`default_nettype none
module ppds_front
   import ppds_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int MAX_DIMS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tuser,
   output logic             item_valid,
   output req_item_type     item,
   input  wire logic        item_ready
);
   localparam int PW = ($clog2(MAX_POINTS + 1) > 6) ? $clog2(MAX_POINTS + 1) : 6;
   localparam int AW = ($clog2(MAX_DIMS + 1) > 3) ? $clog2(MAX_DIMS + 1) : 3;
   localparam int QPW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   req_item_type   q_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0] count_ff;
   req_item_type   beat;
   logic           push, pop;

   always_comb begin
      beat.is_step     = req_tuser;
      beat.point_index = req_tdata[5:0];
      beat.dim_index   = req_tdata[8:6];
      beat.coord_value = $signed(req_tdata[32:9]);
      beat.load_ok     = (PW'(req_tdata[5:0]) < PW'(MAX_POINTS)) &&
                         (AW'(req_tdata[8:6]) < AW'(MAX_DIMS));
   end

   assign req_tready = (count_ff != QCW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_valid && item_ready;
   assign item       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         count_ff <= count_ff + QCW'(push) - QCW'(pop);
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= beat;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("queue overfilled");
endmodule
`default_nettype wire

// ===== hdl/ppds_back.sv =====
// Back end: coordinate store, pair scan sequencer, shared multiplier, root and log
// evaluation, farthest pair tracking and the result register. Depends on ppds_pkg,
// ppds_ram and ppds_isqrt.
`default_nettype none
module ppds_back
   import ppds_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int MAX_DIMS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  req_item_type     item,
   output logic             item_ready,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast
);
   localparam int RW     = $clog2(MAX_POINTS);
   localparam int CW     = (RW + 1 > 7) ? RW + 1 : 7;
   localparam int KW     = $clog2(MAX_DIMS + 1);
   localparam int DW     = (KW > 4) ? KW : 4;
   localparam int ADDR_W = $clog2(MAX_POINTS * MAX_DIMS);

   typedef enum logic [21:0] {
      ST_IDLE      = 22'd1 << 0,
      ST_SETUP     = 22'd1 << 1,
      ST_RD        = 22'd1 << 2,
      ST_M1        = 22'd1 << 3,
      ST_M2        = 22'd1 << 4,
      ST_M3        = 22'd1 << 5,
      ST_M4        = 22'd1 << 6,
      ST_SQ_START  = 22'd1 << 7,
      ST_SQ_1      = 22'd1 << 8,
      ST_SQ_B      = 22'd1 << 9,
      ST_U         = 22'd1 << 10,
      ST_SQ_W      = 22'd1 << 11,
      ST_SQ_V      = 22'd1 << 12,
      ST_S         = 22'd1 << 13,
      ST_NORM      = 22'd1 << 14,
      ST_LN_SQ     = 22'd1 << 15,
      ST_LN_BIT    = 22'd1 << 16,
      ST_LN_MUL    = 22'd1 << 17,
      ST_LN_FIN    = 22'd1 << 18,
      ST_SCALE     = 22'd1 << 19,
      ST_SCALE_FIN = 22'd1 << 20,
      ST_EMIT      = 22'd1 << 21
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]  count_ff;
   logic [3:0]  dims_ff;
   logic        hyp_ff;
   logic [31:0] scale_ff;

   logic [RW-1:0] row_ff, row_in, col_ff, col_in;
   logic [31:0]   best_dist_ff, best_dist_in;
   logic [RW-1:0] best_first_ff, best_first_in, best_second_ff, best_second_in;

   logic [DW-1:0]             k_ff, k_in;
   logic [SQ_IN_W-1:0]        sum_ff, sum_in, ssb_ff, ssb_in;
   logic signed [SQ_IN_W-1:0] lor_ff, lor_in;
   logic [SQ_OUT_W-1:0]       x0a_ff, x0a_in, rw_ff, rw_in;
   logic [SQ_IN_W-1:0]        u_ff, u_in;
   logic [S_W-1:0]            s_ff, s_in;
   logic [E_W-1:0]            e_ff, e_in, i_ff, i_in;
   logic [M_W-1:0]            m_ff, m_in;
   logic [L_W-1:0]            l_ff, l_in;
   logic [SQ_OUT_W-1:0]       raw_ff, raw_in;
   logic [31:0]               dist_ff, dist_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p_ff;

   logic                sq_start;
   logic [SQ_IN_W-1:0]  sq_operand;
   sq_rsp_type          sq_rsp;

   logic              ram_we;
   logic [ADDR_W-1:0] wr_addr, addr_a, addr_b;
   logic [23:0]       rd_a, rd_b;

   logic [CW-1:0] n_c, rowx, colx;
   logic [DW-1:0] d_c;
   logic          scan_last;
   logic signed [24:0] diff;
   logic signed [S_W-1:0] u_full;
   logic [31:0] mm;
   logic [31:0] dist_c;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd2;
         dims_ff  <= 4'd1;
         hyp_ff   <= 1'b0;
         scale_ff <= 32'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POINT_COUNT: count_ff <= csr_wdata[6:0];
            CSR_DIMS:        dims_ff  <= csr_wdata[3:0];
            CSR_HYPERBOLIC:  hyp_ff   <= csr_wdata[0];
            CSR_SCALE:       scale_ff <= csr_wdata;
            default:         hyp_ff   <= hyp_ff;
         endcase
      end
   end

   always_comb begin
      n_c = CW'(count_ff);
      if (n_c < CW'(2)) n_c = CW'(2);
      if (n_c > CW'(MAX_POINTS)) n_c = CW'(MAX_POINTS);
      d_c = DW'(dims_ff);
      if (d_c == '0) d_c = DW'(1);
      if (d_c > DW'(MAX_DIMS)) d_c = DW'(MAX_DIMS);
   end

   assign rowx      = CW'(row_ff);
   assign colx      = CW'(col_ff);
   assign scan_last = (rowx == n_c - CW'(2)) && (colx == n_c - CW'(1));

   assign wr_addr = ADDR_W'(ADDR_W'(item.point_index) * ADDR_W'(MAX_DIMS)
                            + ADDR_W'(item.dim_index));
   assign addr_a  = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(MAX_DIMS) + ADDR_W'(k_ff));
   assign addr_b  = ADDR_W'(ADDR_W'(col_ff) * ADDR_W'(MAX_DIMS) + ADDR_W'(k_ff));

   ppds_ram #(.WIDTH(24), .DEPTH(MAX_POINTS * MAX_DIMS)) u_store (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (wr_addr),
      .wr_data   (item.coord_value),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   ppds_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .rsp     (sq_rsp)
   );

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   assign diff   = 25'($signed(rd_a)) - 25'($signed(rd_b));
   assign u_full = $signed(mul_p_ff[S_W-1:0]) - S_W'(lor_ff);
   assign mm     = mul_p_ff[61:30];

   always_comb begin
      if (mul_p_ff[PROD_W-1:48] != '0) dist_c = 32'hFFFF_FFFF;
      else                              dist_c = mul_p_ff[47:16];
   end

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      best_dist_in   = best_dist_ff;
      best_first_in  = best_first_ff;
      best_second_in = best_second_ff;
      k_in   = k_ff;
      sum_in = sum_ff;
      ssb_in = ssb_ff;
      lor_in = lor_ff;
      x0a_in = x0a_ff;
      rw_in  = rw_ff;
      u_in   = u_ff;
      s_in   = s_ff;
      e_in   = e_ff;
      i_in   = i_ff;
      m_in   = m_ff;
      l_in   = l_ff;
      raw_in = raw_ff;
      dist_in = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      item_ready = 1'b0;
      ram_we     = 1'b0;
      sq_start   = 1'b0;
      sq_operand = sum_ff;
      mul_a      = '0;
      mul_b      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (!item.is_step) begin
                  // a load writes its coordinate when in range and restarts the scan
                  ram_we         = item.load_ok;
                  item_ready     = 1'b1;
                  row_in         = '0;
                  col_in         = RW'(1);
                  best_dist_in   = '0;
                  best_first_in  = '0;
                  best_second_in = '0;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (colx >= n_c || rowx >= colx || (row_ff == '0 && col_ff == RW'(1))) begin
               row_in         = '0;
               col_in         = RW'(1);
               best_dist_in   = '0;
               best_first_in  = '0;
               best_second_in = '0;
            end
            k_in     = '0;
            sum_in   = hyp_ff ? ONE_Q32 : '0;
            ssb_in   = ONE_Q32;
            lor_in   = '0;
            state_in = ST_RD;
         end
         ST_RD: state_in = ST_M1;
         ST_M1: begin
            if (hyp_ff) begin
               mul_a = MUL_W'($signed(rd_a));
               mul_b = MUL_W'($signed(rd_b));
            end else begin
               mul_a = MUL_W'(diff);
               mul_b = MUL_W'(diff);
            end
            state_in = ST_M2;
         end
         ST_M2: begin
            if (hyp_ff) begin
               lor_in   = lor_ff + $signed(mul_p_ff[SQ_IN_W-1:0]);
               mul_a    = MUL_W'($signed(rd_a));
               mul_b    = MUL_W'($signed(rd_a));
               state_in = ST_M3;
            end else begin
               sum_in = sum_ff + mul_p_ff[SQ_IN_W-1:0];
               if (k_ff + DW'(1) < d_c) begin
                  k_in     = k_ff + DW'(1);
                  state_in = ST_RD;
               end else begin
                  state_in = ST_SQ_START;
               end
            end
         end
         ST_M3: begin
            sum_in   = sum_ff + mul_p_ff[SQ_IN_W-1:0];
            mul_a    = MUL_W'($signed(rd_b));
            mul_b    = MUL_W'($signed(rd_b));
            state_in = ST_M4;
         end
         ST_M4: begin
            ssb_in = ssb_ff + mul_p_ff[SQ_IN_W-1:0];
            if (k_ff + DW'(1) < d_c) begin
               k_in     = k_ff + DW'(1);
               state_in = ST_RD;
            end else begin
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START: begin
            sq_start   = 1'b1;
            sq_operand = sum_ff;
            state_in   = ST_SQ_1;
         end
         ST_SQ_1: begin
            if (sq_rsp.done) begin
               if (hyp_ff) begin
                  x0a_in     = sq_rsp.root;
                  sq_start   = 1'b1;
                  sq_operand = ssb_ff;
                  state_in   = ST_SQ_B;
               end else begin
                  raw_in   = sq_rsp.root;
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SQ_B: begin
            if (sq_rsp.done) begin
               mul_a    = MUL_W'(x0a_ff);
               mul_b    = MUL_W'(sq_rsp.root);
               state_in = ST_U;
            end
         end
         ST_U: begin
            // clamp u to at least one
            if (u_full < $signed(S_W'(ONE_Q32))) u_in = ONE_Q32;
            else                                 u_in = u_full[SQ_IN_W-1:0];
            sq_start   = 1'b1;
            sq_operand = u_in - ONE_Q32;
            state_in   = ST_SQ_W;
         end
         ST_SQ_W: begin
            if (sq_rsp.done) begin
               rw_in      = sq_rsp.root;
               sq_start   = 1'b1;
               sq_operand = u_ff + ONE_Q32;
               state_in   = ST_SQ_V;
            end
         end
         ST_SQ_V: begin
            if (sq_rsp.done) begin
               mul_a    = MUL_W'(rw_ff);
               mul_b    = MUL_W'(sq_rsp.root);
               state_in = ST_S;
            end
         end
         ST_S: begin
            s_in     = S_W'(u_ff) + mul_p_ff[S_W-1:0];
            e_in     = '0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // shift down until the top bit sits at position 32
            if (s_ff[S_W-1:33] != '0) begin
               s_in = s_ff >> 1;
               e_in = e_ff + E_W'(1);
            end else begin
               m_in     = s_ff[32:2];
               l_in     = {e_ff, 24'd0};
               i_in     = '0;
               state_in = ST_LN_SQ;
            end
         end
         ST_LN_SQ: begin
            mul_a    = MUL_W'(m_ff);
            mul_b    = MUL_W'(m_ff);
            state_in = ST_LN_BIT;
         end
         ST_LN_BIT: begin
            if (mm[31]) begin
               m_in = mm[31:1];
               l_in = l_ff | (L_W'(1) << (E_W'(LN_BITS - 1) - i_ff));
            end else begin
               m_in = mm[M_W-1:0];
            end
            i_in = i_ff + E_W'(1);
            if (i_ff == E_W'(LN_BITS - 1)) state_in = ST_LN_MUL;
            else                           state_in = ST_LN_SQ;
         end
         ST_LN_MUL: begin
            mul_a    = MUL_W'(l_ff);
            mul_b    = MUL_W'(LN2_Q32);
            state_in = ST_LN_FIN;
         end
         ST_LN_FIN: begin
            raw_in   = mul_p_ff[67:40];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_a    = MUL_W'(raw_ff);
            mul_b    = MUL_W'(scale_ff);
            state_in = ST_SCALE_FIN;
         end
         ST_SCALE_FIN: begin
            dist_in = dist_c;
            if (dist_c > best_dist_ff) begin
               best_dist_in   = dist_c;
               best_first_in  = row_ff;
               best_second_in = col_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'(best_second_ff), 6'(best_first_ff), dist_ff,
                               6'(col_ff), 6'(row_ff)};
               rsp_last_in  = scan_last;
               item_ready   = 1'b1;
               if (scan_last) begin
                  row_in = '0;
                  col_in = RW'(1);
               end else if (colx + CW'(1) < n_c) begin
                  col_in = col_ff + RW'(1);
               end else begin
                  row_in = row_ff + RW'(1);
                  col_in = row_ff + RW'(2);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_ff         <= '0;
         col_ff         <= RW'(1);
         best_dist_ff   <= '0;
         best_first_ff  <= '0;
         best_second_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         best_dist_ff   <= best_dist_in;
         best_first_ff  <= best_first_in;
         best_second_ff <= best_second_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      ssb_ff  <= ssb_in;
      lor_ff  <= lor_in;
      x0a_ff  <= x0a_in;
      rw_ff   <= rw_in;
      u_ff    <= u_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      i_ff    <= i_in;
      m_ff    <= m_in;
      l_ff    <= l_in;
      raw_ff  <= raw_in;
      dist_ff <= dist_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_row_below_col: assert property (@(posedge clock) disable iff (reset)
      row_ff < col_ff)
      else $error("scan row not below scan column");
   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result beat lost on emit");
   a_pop_only_when_done: assert property (@(posedge clock) disable iff (reset)
      item_ready |-> (state_ff == ST_IDLE || state_ff == ST_EMIT))
      else $error("item popped mid-computation");
endmodule
`default_nettype wire

// ===== hdl/pairwise_point_distance_scan_top.sv =====
// Top level of the pairwise point distance scan: front queue plus back end.
// Depends on ppds_pkg, ppds_front and ppds_back.
//
// A step beat walks the coordinates of both points (states RD, M1 and M2 per axis in
// Euclidean mode, RD to M4 in hyperbolic mode, through the two-port coordinate store
// and one shared registered multiplier) and then the root unit: Euclidean steps take
// one root, hyperbolic steps four roots, a normalisation shift and a log by repeated
// squaring. A two-entry queue takes request beats while the back end works, and
// the result register holds a beat until it is taken.
`default_nettype none
module pairwise_point_distance_scan_top
   import ppds_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int MAX_DIMS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // point_index, dim_index, coord_value
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // row_index, col_index, distance, far_first, far_second
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic         item_valid, item_ready;
   req_item_type item;

   ppds_front #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   ppds_back #(.MAX_POINTS(MAX_POINTS), .MAX_DIMS(MAX_DIMS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire
